// File: hdl/caf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package caf_pkg;

    localparam int OP_W   = 5;
    localparam int DATA_W = 16;
    localparam int BYTE_W = 8;

    localparam logic [OP_W-1:0] OP_ADD   = 5'd0;
    localparam logic [OP_W-1:0] OP_ADC   = 5'd1;
    localparam logic [OP_W-1:0] OP_SUB   = 5'd2;
    localparam logic [OP_W-1:0] OP_SBC   = 5'd3;
    localparam logic [OP_W-1:0] OP_AND   = 5'd4;
    localparam logic [OP_W-1:0] OP_OR    = 5'd5;
    localparam logic [OP_W-1:0] OP_XOR   = 5'd6;
    localparam logic [OP_W-1:0] OP_CP    = 5'd7;
    localparam logic [OP_W-1:0] OP_INC   = 5'd8;
    localparam logic [OP_W-1:0] OP_DEC   = 5'd9;
    localparam logic [OP_W-1:0] OP_SWAP  = 5'd10;
    localparam logic [OP_W-1:0] OP_DAA   = 5'd11;
    localparam logic [OP_W-1:0] OP_RLC   = 5'd12;
    localparam logic [OP_W-1:0] OP_RL    = 5'd13;
    localparam logic [OP_W-1:0] OP_RRC   = 5'd14;
    localparam logic [OP_W-1:0] OP_RR    = 5'd15;
    localparam logic [OP_W-1:0] OP_ADD16 = 5'd16;
    localparam logic [OP_W-1:0] OP_CPL   = 5'd17;
    localparam logic [OP_W-1:0] OP_CCF   = 5'd18;
    localparam logic [OP_W-1:0] OP_SCF   = 5'd19;

    localparam logic [BYTE_W-1:0] DAA_HI_ADJ = 8'h60;
    localparam logic [BYTE_W-1:0] DAA_LO_ADJ = 8'h06;
    localparam logic [BYTE_W-1:0] DAA_LIMIT  = 8'h99;
    localparam logic [3:0]        NIBBLE_MAX = 4'h9;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } flags_t;

endpackage

`default_nettype wire

// File: hdl/caf_alu_core.sv
`timescale 1ns / 1ps
`default_nettype none

module caf_alu_core
(
    input  wire logic [caf_pkg::OP_W-1:0]   opcode,
    input  wire logic [caf_pkg::DATA_W-1:0] operand_a,
    input  wire logic [caf_pkg::DATA_W-1:0] operand_b,
    input  wire caf_pkg::flags_t            flags_in,
    output logic [caf_pkg::DATA_W-1:0]      result_value,
    output caf_pkg::flags_t                 flags_next
);

    logic [7:0]  a8;
    logic [7:0]  b8;
    logic        cin_arith;
    logic [8:0]  add9;
    logic [4:0]  add_half;
    logic [8:0]  sub9;
    logic [4:0]  sub_half;
    logic [7:0]  daa_tmp;
    logic [7:0]  daa_val;
    logic        daa_c;
    logic [16:0] add17;
    logic [12:0] add_half16;
    logic [7:0]  r8;

    assign a8 = operand_a[7:0];
    assign b8 = operand_b[7:0];
    assign cin_arith = flags_in.c & ((opcode == caf_pkg::OP_ADC) || (opcode == caf_pkg::OP_SBC));

    assign add9     = {1'b0, a8} + {1'b0, b8} + {8'd0, cin_arith};
    assign add_half = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, cin_arith};
    assign sub9     = {1'b0, a8} - {1'b0, b8} - {8'd0, cin_arith};
    assign sub_half = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, cin_arith};

    assign add17      = {1'b0, operand_a} + {1'b0, operand_b};
    assign add_half16 = {1'b0, operand_a[11:0]} + {1'b0, operand_b[11:0]};

    always_comb
    begin
        daa_c   = flags_in.c;
        daa_tmp = a8;
        daa_val = a8;
        if (!flags_in.n)
        begin
            if (flags_in.c || (a8 > caf_pkg::DAA_LIMIT))
            begin
                daa_tmp = a8 + caf_pkg::DAA_HI_ADJ;
                daa_c   = 1'b1;
            end
            if (flags_in.h || (a8[3:0] > caf_pkg::NIBBLE_MAX))
                daa_val = daa_tmp + caf_pkg::DAA_LO_ADJ;
            else
                daa_val = daa_tmp;
        end
        else
        begin
            if (flags_in.c)
                daa_tmp = a8 - caf_pkg::DAA_HI_ADJ;
            if (flags_in.h)
                daa_val = daa_tmp - caf_pkg::DAA_LO_ADJ;
            else
                daa_val = daa_tmp;
        end
    end

    always_comb
    begin
        r8           = a8;
        flags_next   = flags_in;
        result_value = {8'd0, a8};
        case (opcode)
            caf_pkg::OP_ADD, caf_pkg::OP_ADC:
            begin
                r8         = add9[7:0];
                flags_next = '{z: (add9[7:0] == 8'd0), n: 1'b0, h: add_half[4], c: add9[8]};
            end
            caf_pkg::OP_SUB, caf_pkg::OP_SBC:
            begin
                r8         = sub9[7:0];
                flags_next = '{z: (sub9[7:0] == 8'd0), n: 1'b1, h: sub_half[4], c: sub9[8]};
            end
            caf_pkg::OP_CP:
            begin
                flags_next = '{z: (sub9[7:0] == 8'd0), n: 1'b1, h: sub_half[4], c: sub9[8]};
            end
            caf_pkg::OP_AND:
            begin
                r8         = a8 & b8;
                flags_next = '{z: ((a8 & b8) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
            end
            caf_pkg::OP_OR:
            begin
                r8         = a8 | b8;
                flags_next = '{z: ((a8 | b8) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            caf_pkg::OP_XOR:
            begin
                r8         = a8 ^ b8;
                flags_next = '{z: ((a8 ^ b8) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            caf_pkg::OP_INC:
            begin
                r8         = a8 + 8'd1;
                flags_next = '{z: (a8 == 8'hff), n: 1'b0, h: (a8[3:0] == 4'hf), c: flags_in.c};
            end
            caf_pkg::OP_DEC:
            begin
                r8         = a8 - 8'd1;
                flags_next = '{z: (a8 == 8'h01), n: 1'b1, h: (a8[3:0] == 4'h0), c: flags_in.c};
            end
            caf_pkg::OP_SWAP:
            begin
                r8         = {a8[3:0], a8[7:4]};
                flags_next = '{z: (a8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            caf_pkg::OP_DAA:
            begin
                r8         = daa_val;
                flags_next = '{z: (daa_val == 8'd0), n: flags_in.n, h: 1'b0, c: daa_c};
            end
            caf_pkg::OP_RLC:
            begin
                r8         = {a8[6:0], a8[7]};
                flags_next = '{z: (a8 == 8'd0), n: 1'b0, h: 1'b0, c: a8[7]};
            end
            caf_pkg::OP_RL:
            begin
                r8         = {a8[6:0], flags_in.c};
                flags_next = '{z: ({a8[6:0], flags_in.c} == 8'd0), n: 1'b0, h: 1'b0, c: a8[7]};
            end
            caf_pkg::OP_RRC:
            begin
                r8         = {a8[0], a8[7:1]};
                flags_next = '{z: (a8 == 8'd0), n: 1'b0, h: 1'b0, c: a8[0]};
            end
            caf_pkg::OP_RR:
            begin
                r8         = {flags_in.c, a8[7:1]};
                flags_next = '{z: ({flags_in.c, a8[7:1]} == 8'd0), n: 1'b0, h: 1'b0, c: a8[0]};
            end
            caf_pkg::OP_CPL:
            begin
                r8         = ~a8;
                flags_next = '{z: flags_in.z, n: 1'b1, h: 1'b1, c: flags_in.c};
            end
            caf_pkg::OP_CCF:
            begin
                flags_next = '{z: flags_in.z, n: 1'b0, h: 1'b0, c: ~flags_in.c};
            end
            caf_pkg::OP_SCF:
            begin
                flags_next = '{z: flags_in.z, n: 1'b0, h: 1'b0, c: 1'b1};
            end
            default:
            begin
                r8         = a8;
                flags_next = flags_in;
            end
        endcase
        if (opcode == caf_pkg::OP_ADD16)
        begin
            result_value = add17[15:0];
            flags_next   = '{z: flags_in.z, n: 1'b0, h: add_half16[12], c: add17[16]};
        end
        else
            result_value = {8'd0, r8};
    end

endmodule

`default_nettype wire

// File: hdl/cpu_alu_with_flags_top.sv
// 8-bit ALU with a 16-bit add and a Z/N/H/C flag register, one request per
// cycle. A request is captured in an input register, evaluated in one pass of
// combinational logic against the current flags, and written with its new
// flags to the result register once that register is free, so rsp_valid
// rises as the request reaches the result register. Throughput is one
// request per cycle while rsp_stall is low. The flag register updates as each
// request moves to the result register, so the next request always sees the
// flags of the one before it. Flags reset to zero.
`timescale 1ns / 1ps
`default_nettype none

module cpu_alu_with_flags_top
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic [caf_pkg::OP_W-1:0]      opcode,
    input  wire logic [caf_pkg::DATA_W-1:0]    operand_a,
    input  wire logic [caf_pkg::DATA_W-1:0]    operand_b,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output logic [caf_pkg::DATA_W-1:0]         result_value,
    output logic [3:0]                         flags_out
);

    logic                        s1_vld_reg;
    logic [caf_pkg::OP_W-1:0]    s1_op_reg;
    logic [caf_pkg::DATA_W-1:0]  s1_a_reg;
    logic [caf_pkg::DATA_W-1:0]  s1_b_reg;
    logic                        out_vld_reg;
    logic [caf_pkg::DATA_W-1:0]  res_reg;
    caf_pkg::flags_t             flag_reg;
    caf_pkg::flags_t             flag_next;
    logic [caf_pkg::DATA_W-1:0]  res_next;
    logic                        s1_adv;
    logic                        req_take;

    assign s1_adv    = s1_vld_reg && (!out_vld_reg || !rsp_stall);
    assign req_stall = s1_vld_reg && !s1_adv;
    assign req_take  = req_valid && !req_stall;

    caf_alu_core u_core
    (
        .opcode       (s1_op_reg),
        .operand_a    (s1_a_reg),
        .operand_b    (s1_b_reg),
        .flags_in     (flag_reg),
        .result_value (res_next),
        .flags_next   (flag_next)
    );

    // hold the request until the result register frees up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (req_take)
            s1_vld_reg <= 1'b1;
        else if (s1_adv)
            s1_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            s1_op_reg <= opcode;
            s1_a_reg  <= operand_a;
            s1_b_reg  <= operand_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            flag_reg    <= '0;
        end
        else
        begin
            if (s1_adv)
            begin
                out_vld_reg <= 1'b1;
                flag_reg    <= flag_next;
            end
            else if (!rsp_stall)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            res_reg <= res_next;
    end

    assign rsp_valid    = out_vld_reg;
    assign result_value = res_reg;
    assign flags_out    = flag_reg;

    a_stall_needs_pending : assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> s1_vld_reg)
        else $error("input stalled with no request pending");

    a_adv_loads_output : assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_vld_reg)
        else $error("advanced request did not reach the result register");

    a_blocked_holds : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg && !s1_adv) |=> (s1_vld_reg && $stable(s1_op_reg) && $stable(s1_a_reg)))
        else $error("blocked request lost or changed");

    a_flags_track : assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && rsp_stall) |=> $stable(flag_reg))
        else $error("flags changed while result stalled");

endmodule

`default_nettype wire
